/* sv/ical_line_escape_fold_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the content line escaper and folder
// Wrap concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ICAL_LINE_ESCAPE_FOLD_CORE_ASSERT_SVH
`define ICAL_LINE_ESCAPE_FOLD_CORE_ASSERT_SVH

// check cons in the same cycle as ante
`define LEF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// check cons in the cycle after ante
`define LEF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/lef_pkg.sv */
// ----------------------------------------------------------------------------
// lef_pkg
// Shared codes, characters and command types of the line escaper and folder.
// ----------------------------------------------------------------------------
`default_nettype none

package lef_pkg;

	localparam logic [7:0] LIMIT_RESET = 8'd74;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_N     = 8'h6E;

	// one item expands to at most four back end operations
	localparam int OPS_MAX  = 4;
	localparam int OP_IDX_W = 2;

	typedef enum logic [2:0] {
		OP_NONE        = 3'd0,
		OP_PUT         = 3'd1,  // fold check for one octet, then send the byte
		OP_FLUSH       = 3'd2,  // fold check for the pending character, send it
		OP_FLUSH_STORE = 3'd3,  // as flush, then open a new character
		OP_STORE       = 3'd4,  // open a new character, nothing pending
		OP_APPEND      = 3'd5,  // add a continuation byte
		OP_CRLF        = 3'd6   // end of line
	} op_code_t;

	typedef struct packed {
		op_code_t   code;
		logic [7:0] data;
	} op_t;

	typedef struct packed {
		op_t [OPS_MAX-1:0]     ops;
		logic [OP_IDX_W-1:0]   last_op;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

endpackage

`default_nettype wire

/* sv/lef_front.sv */
// ----------------------------------------------------------------------------
// lef_front
// Accepts input items, expands escapes and turns each item that leaves work into a command.
// ----------------------------------------------------------------------------
`default_nettype none

module lef_front import lef_pkg::*; #(
	parameter int CHAR_BYTES_MAX = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] text_byte,
	input  wire logic       literal,
	input  wire logic       end_of_line,
	input  q_status_t       q_stat,
	output logic            push,
	output cmd_t            cmd
);

	localparam int LEN_W = $clog2(CHAR_BYTES_MAX + 1);

	// length of the pending character as the back end will see it
	logic [LEN_W-1:0] slen_q;
	logic [LEN_W-1:0] slen_d;
	logic [1:0]       n_takes;
	logic [7:0]       t0;
	logic [7:0]       t1;
	logic [2:0]       n_ops;
	logic             cont0;
	logic             accept;

	always_comb begin
		n_takes = 2'd1;
		t0      = text_byte;
		t1      = text_byte;
		if (!literal) begin
			unique case (text_byte) inside
				CH_BSL, CH_COMMA, CH_SEMI: begin
					n_takes = 2'd2;
					t0      = CH_BSL;
				end
				CH_LF: begin
					n_takes = 2'd2;
					t0      = CH_BSL;
					t1      = CH_N;
				end
				CH_CR: n_takes = 2'd0;
				default: n_takes = 2'd1;
			endcase
		end
	end

	assign cont0 = (t0[7:6] == 2'b10) && (slen_q != '0) &&
		(slen_q < LEN_W'(CHAR_BYTES_MAX));

	always_comb begin
		cmd    = '0;
		n_ops  = 3'd0;
		slen_d = slen_q;
		if (n_takes != 2'd0) begin
			if (!t0[7]) begin
				if (slen_q != '0) begin
					cmd.ops[n_ops[OP_IDX_W-1:0]] = '{code: OP_FLUSH, data: 8'h00};
					n_ops = n_ops + 3'd1;
				end
				cmd.ops[n_ops[OP_IDX_W-1:0]] = '{code: OP_PUT, data: t0};
				n_ops  = n_ops + 3'd1;
				slen_d = '0;
			end else if (cont0) begin
				cmd.ops[n_ops[OP_IDX_W-1:0]] = '{code: OP_APPEND, data: t0};
				n_ops  = n_ops + 3'd1;
				slen_d = slen_q + LEN_W'(1);
			end else begin
				cmd.ops[n_ops[OP_IDX_W-1:0]] =
					'{code: (slen_q != '0) ? OP_FLUSH_STORE : OP_STORE, data: t0};
				n_ops  = n_ops + 3'd1;
				slen_d = LEN_W'(1);
			end
		end
		// second take of an escape pair is always plain ASCII
		if (n_takes == 2'd2) begin
			cmd.ops[n_ops[OP_IDX_W-1:0]] = '{code: OP_PUT, data: t1};
			n_ops = n_ops + 3'd1;
		end
		if (end_of_line) begin
			if (slen_d != '0) begin
				cmd.ops[n_ops[OP_IDX_W-1:0]] = '{code: OP_FLUSH, data: 8'h00};
				n_ops = n_ops + 3'd1;
			end
			cmd.ops[n_ops[OP_IDX_W-1:0]] = '{code: OP_CRLF, data: 8'h00};
			n_ops  = n_ops + 3'd1;
			slen_d = '0;
		end
		cmd.last_op = n_ops[OP_IDX_W-1:0] - OP_IDX_W'(1);
	end

	assign in_ready = !q_stat.full;
	assign accept   = in_valid && in_ready;
	// drop items that leave nothing to do
	assign push     = accept && (n_ops != 3'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slen_q <= '0;
		end else if (accept) begin
			slen_q <= slen_d;
		end
	end

endmodule

`default_nettype wire

/* sv/lef_cmd_fifo.sv */
// ----------------------------------------------------------------------------
// lef_cmd_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lef_cmd_fifo import lef_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  cmd_t      wr_cmd,
	input  wire logic pop,
	output cmd_t      rd_cmd,
	output q_status_t q_stat
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign rd_cmd       = mem_q[rd_ptr_q];
	assign q_stat.empty = (count_q == '0);
	assign q_stat.full  = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* sv/lef_back.sv */
// ----------------------------------------------------------------------------
// lef_back
// Runs commands: character buffer, line octet count, folding, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lef_back import lef_pkg::*; #(
	parameter int CHAR_BYTES_MAX = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [7:0] limit,
	input  cmd_t            cmd,
	input  q_status_t       q_stat,
	output logic            pop,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run
);

	localparam int LEN_W = $clog2(CHAR_BYTES_MAX + 1);
	localparam int IDX_W = $clog2(CHAR_BYTES_MAX);
	localparam int CAP   = CHAR_BYTES_MAX + 7;
	localparam int CNT_W = $clog2(CAP + 1);

	typedef enum logic [3:0] {
		PH_CHECK = 4'b0001,
		PH_LF    = 4'b0010,
		PH_SP    = 4'b0100,
		PH_BODY  = 4'b1000
	} phase_t;

	phase_t              phase_q;
	phase_t              phase_d;
	logic [OP_IDX_W-1:0] op_q;
	logic [IDX_W-1:0]    fi_q;
	logic [IDX_W-1:0]    fi_d;
	logic [LEN_W-1:0]    len_q;
	logic [LEN_W-1:0]    len_d;
	logic [7:0]          octets_q;
	logic [7:0]          octets_d;
	logic [CNT_W-1:0]    cnt_q;
	logic [7:0]          buf_q [CHAR_BYTES_MAX];
	logic                buf_we;
	logic [IDX_W-1:0]    buf_addr;

	op_t              cur_op;
	logic             op_final;
	logic [LEN_W-1:0] fold_len;
	logic [8:0]       fold_sum;
	logic             fold_hit;
	logic             body_now;
	logic             emit;
	logic [7:0]       emit_byte;
	logic             op_done;
	logic             capped;
	logic             emit_real;
	logic             out_ok;
	logic             go;
	logic             flush_end;

	function automatic logic [7:0] sat_add(logic [7:0] a, logic [LEN_W-1:0] b);
		logic [8:0] s;
		s = {1'b0, a} + 9'(b);
		return s[8] ? 8'hFF : s[7:0];
	endfunction

	assign cur_op    = cmd.ops[op_q];
	assign op_final  = (op_q == cmd.last_op);
	assign fold_len  = (cur_op.code == OP_PUT) ? LEN_W'(1) : len_q;
	assign fold_sum  = {1'b0, octets_q} + 9'(fold_len);
	assign fold_hit  = (fold_sum > {1'b0, limit}) && (octets_q > 8'd1);
	assign flush_end = (LEN_W'(fi_q) + LEN_W'(1) == len_q);

	always_comb begin
		phase_d   = phase_q;
		fi_d      = fi_q;
		len_d     = len_q;
		octets_d  = octets_q;
		buf_we    = 1'b0;
		buf_addr  = '0;
		body_now  = 1'b0;
		emit      = 1'b0;
		emit_byte = '0;
		op_done   = 1'b0;
		unique case (phase_q)
			PH_CHECK: begin
				unique case (cur_op.code) inside
					OP_PUT, OP_FLUSH, OP_FLUSH_STORE: begin
						if (fold_hit) begin
							emit      = 1'b1;
							emit_byte = CH_CR;
							phase_d   = PH_LF;
						end else begin
							body_now = 1'b1;
						end
					end
					OP_CRLF: begin
						emit      = 1'b1;
						emit_byte = CH_CR;
						phase_d   = PH_LF;
					end
					OP_STORE: begin
						buf_we   = 1'b1;
						buf_addr = '0;
						len_d    = LEN_W'(1);
						op_done  = 1'b1;
					end
					OP_APPEND: begin
						buf_we   = 1'b1;
						buf_addr = len_q[IDX_W-1:0];
						len_d    = len_q + LEN_W'(1);
						op_done  = 1'b1;
					end
					default: op_done = 1'b1;
				endcase
			end
			PH_LF: begin
				emit      = 1'b1;
				emit_byte = CH_LF;
				if (cur_op.code == OP_CRLF) begin
					octets_d = '0;
					op_done  = 1'b1;
				end else begin
					phase_d = PH_SP;
				end
			end
			PH_SP: begin
				emit      = 1'b1;
				emit_byte = CH_SP;
				octets_d  = 8'd1;
				phase_d   = PH_BODY;
			end
			PH_BODY: body_now = 1'b1;
			default: phase_d = PH_CHECK;
		endcase

		if (body_now) begin
			emit = 1'b1;
			if (cur_op.code == OP_PUT) begin
				emit_byte = cur_op.data;
				octets_d  = sat_add(octets_q, LEN_W'(1));
				op_done   = 1'b1;
			end else begin
				emit_byte = buf_q[fi_q];
				if (flush_end) begin
					octets_d = sat_add(octets_q, len_q);
					fi_d     = '0;
					op_done  = 1'b1;
					// open the next character in the cycle its predecessor leaves
					if (cur_op.code == OP_FLUSH_STORE) begin
						buf_we   = 1'b1;
						buf_addr = '0;
						len_d    = LEN_W'(1);
					end else begin
						len_d = '0;
					end
				end else begin
					fi_d    = fi_q + IDX_W'(1);
					phase_d = PH_BODY;
				end
			end
		end

		if (op_done) begin
			phase_d = PH_CHECK;
		end
	end

	// octets past the per-item cap are dropped, state still advances
	assign capped    = (cnt_q == CNT_W'(CAP));
	assign emit_real = emit && !capped;
	assign out_ok    = !out_valid || out_ready;
	assign go        = !q_stat.empty && (!emit_real || out_ok);
	assign pop       = go && op_done && op_final;

	always_ff @(posedge clk) begin
		if (go && buf_we) begin
			buf_q[buf_addr] <= cur_op.data;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit_real) begin
			out_byte    <= emit_byte;
			last_of_run <= (op_done && op_final) || (cnt_q == CNT_W'(CAP - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_CHECK;
			op_q      <= '0;
			fi_q      <= '0;
			len_q     <= '0;
			octets_q  <= '0;
			cnt_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (go) begin
				phase_q  <= phase_d;
				fi_q     <= fi_d;
				len_q    <= len_d;
				octets_q <= octets_d;
				if (op_done) begin
					op_q <= op_final ? '0 : op_q + OP_IDX_W'(1);
				end
				if (op_done && op_final) begin
					cnt_q <= '0;
				end else if (emit_real) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (go && emit_real) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/ical_line_escape_fold_core.sv */
// ----------------------------------------------------------------------------
// ical_line_escape_fold_core
// Escapes and folds one content line at a time, UTF-8 characters kept whole.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+----------------------
//  input    | text_byte, literal, end_of_line          | in_valid / in_ready
//  output   | out_byte, last_of_run                    | out_valid / out_ready
//  config   | cfg_data (octet limit)                   | cfg_write, no wait
//
// One output octet per cycle at most.
// An item produces octets for escape pairs, fold CR LF SP, character flush
// and closing CR LF; a lead byte with nothing pending or a continuation
// byte is stored in the character buffer without producing an octet.
// The front accepts while the CMD_DEPTH entry command queue has room.
// Reset clears the queue, the pending character and the line octet count.
// ----------------------------------------------------------------------------
`default_nettype none

module ical_line_escape_fold_core import lef_pkg::*; #(
	parameter int CHAR_BYTES_MAX = 4,
	parameter int CMD_DEPTH      = 4
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_write,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] text_byte,
	input  wire logic       literal,
	input  wire logic       end_of_line,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            last_of_run
);

	`include "ical_line_escape_fold_core_assert.svh"

	logic [7:0] limit_q;
	logic       push;
	logic       pop;
	cmd_t       wr_cmd;
	cmd_t       rd_cmd;
	q_status_t  q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_write) begin
			limit_q <= cfg_data;
		end
	end

	lef_front #(
		.CHAR_BYTES_MAX(CHAR_BYTES_MAX)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.text_byte  (text_byte),
		.literal    (literal),
		.end_of_line(end_of_line),
		.q_stat     (q_stat),
		.push       (push),
		.cmd        (wr_cmd)
	);

	lef_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wr_cmd(wr_cmd),
		.pop   (pop),
		.rd_cmd(rd_cmd),
		.q_stat(q_stat)
	);

	lef_back #(
		.CHAR_BYTES_MAX(CHAR_BYTES_MAX)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.limit      (limit_q),
		.cmd        (rd_cmd),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

	`LEF_ASSERT_NOW(a_no_push_when_full, q_stat.full, !push, "command pushed into full queue")
	`LEF_ASSERT_NOW(a_no_pop_when_empty, q_stat.empty, !pop, "command popped from empty queue")
	`LEF_ASSERT_NOW(a_bare_cr_dropped, in_valid && in_ready && !literal && text_byte == CH_CR && !end_of_line, !push, "escaped CR produced a command")
	`LEF_ASSERT_NEXT(a_pop_advances, pop && !push, !q_stat.full, "queue still full after a pop")

endmodule

`default_nettype wire
